@@ sv/two_level_page_table_walker_assert.svh @@
// Assertion macros used by the page table walker module ptw_walk.
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ptw_pkg.sv @@
// Types and constants of the page table walker.
package ptw_pkg;

  localparam int unsigned PPN_W    = 20;
  localparam int unsigned OFFS_W   = 12;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned ADDR_W   = 32;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_RESPONSE  = 1'b1;

  localparam logic KIND_READ_REQ = 1'b0;
  localparam logic KIND_DONE     = 1'b1;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_FIRST  = 2'd1;
  localparam logic [1:0] FAULT_SECOND = 2'd2;
  localparam logic [1:0] FAULT_PERM   = 2'd3;

  localparam logic [1:0] ACC_FETCH = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_WRITE = 2'd2;

  // Entry bit positions
  localparam int unsigned PTE_V = 0;
  localparam int unsigned PTE_R = 1;
  localparam int unsigned PTE_W = 2;
  localparam int unsigned PTE_X = 3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } walk_phase_t;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] virtual_address;
    logic [1:0]        access_type;
    logic [ADDR_W-1:0] read_data;
  } req_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] out_address;
    logic [1:0]        fault_code;
  } walk_result_t;

endpackage

@@ sv/ptw_req_if.sv @@
// Input channel: translate requests and memory read responses.
interface ptw_req_if;
  import ptw_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] virtual_address;
  logic [1:0]        access_type;
  logic [ADDR_W-1:0] read_data;

  modport source (output valid, opcode, virtual_address, access_type, read_data,
                  input ready);
  modport sink   (input valid, opcode, virtual_address, access_type, read_data,
                  output ready);
endinterface

@@ sv/ptw_rsp_if.sv @@
// Output channel: read requests and finished translations.
interface ptw_rsp_if;
  import ptw_pkg::*;
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [ADDR_W-1:0] out_address;
  logic [1:0]        fault_code;

  modport source (output valid, result_kind, out_address, fault_code, input ready);
  modport sink   (input valid, result_kind, out_address, fault_code, output ready);
endinterface

@@ sv/ptw_cfg_if.sv @@
// Configuration write channel for the root page number.
interface ptw_cfg_if;
  import ptw_pkg::*;
  logic             valid;
  logic             ready;
  logic [PPN_W-1:0] root_page_number;

  modport source (output valid, root_page_number, input ready);
  modport sink   (input valid, root_page_number, output ready);
endinterface

@@ sv/ptw_in_stage.sv @@
// Input register of the walker.
module ptw_in_stage
  import ptw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  req_item_t in_item,
  output logic      item_valid,
  output req_item_t item,
  input  logic      fire
);

  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

@@ sv/ptw_walk.sv @@
// Walk phase, saved request fields, root register and result formation.
module ptw_walk
  import ptw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [PPN_W-1:0] cfg_root,
  input  logic             item_valid,
  input  req_item_t        item,
  input  logic             fire,
  output logic             res_valid,
  output walk_result_t     res
);

  `include "two_level_page_table_walker_assert.svh"

  walk_phase_t        phase, phase_next;
  logic [PPN_W-1:0]   root_page_number;
  logic [INDEX_W-1:0] saved_second_index;
  logic [OFFS_W-1:0]  saved_page_offset;
  logic [1:0]         saved_access_type;
  logic               save_req;
  logic               allowed;
  logic [ADDR_W-1:0]  word;

  assign word = item.read_data;

  always_comb begin
    case (saved_access_type)
      ACC_FETCH: allowed = word[PTE_X];
      ACC_READ:  allowed = word[PTE_R];
      ACC_WRITE: allowed = word[PTE_W];
      default:   allowed = 1'b1;
    endcase
  end

  always_comb begin
    phase_next = phase;
    save_req   = 1'b0;
    res_valid  = 1'b0;
    res        = '{result_kind: KIND_READ_REQ, out_address: '0, fault_code: FAULT_NONE};
    if (item_valid) begin
      if (item.opcode == OP_TRANSLATE) begin
        if (phase == PH_IDLE) begin
          save_req        = 1'b1;
          phase_next      = PH_FIRST;
          res_valid       = 1'b1;
          res.out_address = {root_page_number, item.virtual_address[31:22], 2'b00};
        end
      end else begin
        unique case (phase)
          PH_FIRST: begin
            res_valid = 1'b1;
            if (!word[PTE_V]) begin
              phase_next      = PH_IDLE;
              res.result_kind = KIND_DONE;
              res.fault_code  = FAULT_FIRST;
            end else begin
              phase_next      = PH_SECOND;
              res.out_address = {word[31:12], saved_second_index, 2'b00};
            end
          end
          PH_SECOND: begin
            res_valid       = 1'b1;
            phase_next      = PH_IDLE;
            res.result_kind = KIND_DONE;
            if (!word[PTE_V]) begin
              res.fault_code = FAULT_SECOND;
            end else if (!allowed) begin
              res.fault_code = FAULT_PERM;
            end else begin
              res.out_address = {word[31:12], saved_page_offset};
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      root_page_number   <= '0;
      saved_second_index <= '0;
      saved_page_offset  <= '0;
      saved_access_type  <= '0;
    end else begin
      if (cfg_we) begin
        root_page_number <= cfg_root;
      end
      if (fire) begin
        phase <= phase_next;
        if (save_req) begin
          saved_second_index <= item.virtual_address[21:12];
          saved_page_offset  <= item.virtual_address[11:0];
          saved_access_type  <= item.access_type;
        end
      end
    end
  end

  `PTW_ASSERT_NOW(a_fault_zero_addr, res_valid && res.fault_code != FAULT_NONE,
    res.out_address == '0 && res.result_kind == KIND_DONE, "fault with nonzero address")
  `PTW_ASSERT_NOW(a_req_no_fault, res_valid && res.result_kind == KIND_READ_REQ,
    res.fault_code == FAULT_NONE, "read request carries a fault")
  `PTW_ASSERT_NEXT(a_start_walk, fire && item_valid && item.opcode == OP_TRANSLATE && phase == PH_IDLE,
    phase == PH_FIRST, "translate did not start a walk")
  `PTW_ASSERT_NEXT(a_done_idle, fire && res_valid && res.result_kind == KIND_DONE,
    phase == PH_IDLE, "walker busy after finishing")

endmodule

@@ sv/ptw_out_stage.sv @@
// Result register of the walker.
module ptw_out_stage
  import ptw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  walk_result_t load_res,
  output logic         out_free,
  output logic         out_valid,
  input  logic         out_ready,
  output walk_result_t out_res
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      out_res <= load_res;
    end
  end

endmodule

@@ sv/two_level_page_table_walker.sv @@
// Two-level page table walker: an item is taken every cycle while results are
// taken; each item is held in the input register, where its fields, the walk
// phase, the saved request fields and the root page number form its result,
// and the result is then held in the result register until transferred. Only
// a held result that is not taken stalls the input. Translate requests during
// a walk and memory responses while idle are dropped with no result.
// Configuration writes are always ready and take effect on the next cycle.
module two_level_page_table_walker
  import ptw_pkg::*;
(
  input logic      clk,
  input logic      rst,
  ptw_req_if.sink  req,
  ptw_rsp_if.source rsp,
  ptw_cfg_if.sink  cfg
);

  req_item_t    in_item;
  req_item_t    item;
  logic         item_valid;
  logic         fire;
  logic         res_valid;
  walk_result_t res;
  walk_result_t out_res;
  logic         out_free;

  assign in_item = '{opcode: req.opcode, virtual_address: req.virtual_address,
                     access_type: req.access_type, read_data: req.read_data};
  assign fire    = item_valid && (!res_valid || out_free);
  assign cfg.ready = 1'b1;

  ptw_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .fire       (fire)
  );

  ptw_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_root   (cfg.root_page_number),
    .item_valid (item_valid),
    .item       (item),
    .fire       (fire),
    .res_valid  (res_valid),
    .res        (res)
  );

  ptw_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && res_valid),
    .load_res  (res),
    .out_free  (out_free),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_res   (out_res)
  );

  assign rsp.result_kind = out_res.result_kind;
  assign rsp.out_address = out_res.out_address;
  assign rsp.fault_code  = out_res.fault_code;

endmodule
